@@ rtl/nmea2000_frame_decoder_macros.svh @@
// Assertion macros shared by the frame decoder RTL.
// Each macro builds one clocked concurrent assertion that is disabled during reset.
`ifndef NMEA2000_FRAME_DECODER_MACROS_SVH
`define NMEA2000_FRAME_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define N2KFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define N2KFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/n2kfd_pkg.sv @@
package n2kfd_pkg;

  // Port widths.
  localparam int ID_W      = 29;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int GROUP_W   = 18;
  localparam int PRIO_W    = 3;
  localparam int ADDR_W    = 8;
  localparam int KIND_W    = 4;
  localparam int VALUE_W   = 64;

  // Number of fraction bits in every decoded value.
  localparam int FRAC_BITS = 24;

  // Scaling is done as a multiply by a rounded-up reciprocal with RECIP_SHIFT extra
  // fraction bits. Sixty bits keep the error below the smallest distance to a rounding
  // boundary for every raw value and factor, so the result is exact.
  localparam int MAG_W       = 32;
  localparam int RECIP_SHIFT = 60;
  localparam int COEFF_SHIFT = FRAC_BITS + RECIP_SHIFT;
  localparam int COEFF_W     = COEFF_SHIFT;
  localparam int CHUNK_W     = 32;
  localparam int NCHUNK      = (COEFF_W + CHUNK_W - 1) / CHUNK_W;
  localparam int COEFF_PAD_W = NCHUNK * CHUNK_W;
  localparam int PROD_W      = MAG_W + CHUNK_W;
  localparam int SUM_W       = MAG_W + COEFF_PAD_W;
  localparam int WIDE_W      = 192;

  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RECIP_SHIFT - 1);

  // Unit factors as exact fractions.
  localparam logic [WIDE_W-1:0] WIDE_ONE  = WIDE_W'(1);
  localparam logic [WIDE_W-1:0] ANG_NUM   = WIDE_W'(64'd572957795130823);
  localparam logic [WIDE_W-1:0] ANG_DEN   = WIDE_W'(64'd100000000000000000);
  localparam logic [WIDE_W-1:0] KN_NUM    = WIDE_W'(64'd10000);
  localparam logic [WIDE_W-1:0] KN_DEN    = WIDE_W'(64'd514444);
  localparam logic [WIDE_W-1:0] CENTI_DEN = WIDE_W'(64'd100);
  localparam logic [WIDE_W-1:0] MILLI_DEN = WIDE_W'(64'd1000);
  localparam logic [WIDE_W-1:0] E7_DEN    = WIDE_W'(64'd10000000);

  // Reciprocals rounded up: ceil(num * 2^(FRAC_BITS + RECIP_SHIFT) / den).
  localparam logic [WIDE_W-1:0] ANG_WIDE =
    ((ANG_NUM << COEFF_SHIFT) + ANG_DEN - WIDE_ONE) / ANG_DEN;
  localparam logic [WIDE_W-1:0] KN_WIDE =
    ((KN_NUM << COEFF_SHIFT) + KN_DEN - WIDE_ONE) / KN_DEN;
  localparam logic [WIDE_W-1:0] CENTI_WIDE =
    ((WIDE_ONE << COEFF_SHIFT) + CENTI_DEN - WIDE_ONE) / CENTI_DEN;
  localparam logic [WIDE_W-1:0] MILLI_WIDE =
    ((WIDE_ONE << COEFF_SHIFT) + MILLI_DEN - WIDE_ONE) / MILLI_DEN;
  localparam logic [WIDE_W-1:0] E7_WIDE =
    ((WIDE_ONE << COEFF_SHIFT) + E7_DEN - WIDE_ONE) / E7_DEN;

  localparam logic [COEFF_W-1:0] COEFF_ANGLE = ANG_WIDE[COEFF_W-1:0];
  localparam logic [COEFF_W-1:0] COEFF_KNOTS = KN_WIDE[COEFF_W-1:0];
  localparam logic [COEFF_W-1:0] COEFF_CENTI = CENTI_WIDE[COEFF_W-1:0];
  localparam logic [COEFF_W-1:0] COEFF_MILLI = MILLI_WIDE[COEFF_W-1:0];
  localparam logic [COEFF_W-1:0] COEFF_E7    = E7_WIDE[COEFF_W-1:0];

  // Known parameter group numbers.
  localparam logic [GROUP_W-1:0] PGN_HEADING  = 18'd127250;
  localparam logic [GROUP_W-1:0] PGN_ATTITUDE = 18'd127257;
  localparam logic [GROUP_W-1:0] PGN_SPEED    = 18'd128259;
  localparam logic [GROUP_W-1:0] PGN_DEPTH    = 18'd128267;
  localparam logic [GROUP_W-1:0] PGN_POSITION = 18'd129025;
  localparam logic [GROUP_W-1:0] PGN_COG_SOG  = 18'd129026;
  localparam logic [GROUP_W-1:0] PGN_WIND     = 18'd130306;
  localparam logic [GROUP_W-1:0] PGN_WATER_T  = 18'd130310;

  // PDU2 format starts at this PF value; PS is then part of the group number.
  localparam logic [7:0] PF_PDU2_MIN = 8'd240;

  // Not-available markers.
  localparam logic [15:0] NA_S16 = 16'h7FFF;
  localparam logic [15:0] NA_U16 = 16'hFFFF;
  localparam logic [31:0] NA_S32 = 32'h7FFFFFFF;
  localparam logic [31:0] NA_U32 = 32'hFFFFFFFF;

  // Water temperature offset in hundredths of a kelvin.
  localparam logic [MAG_W-1:0] KELVIN_CENTI = MAG_W'(27315);

  localparam logic [2:0] WIND_REF_APPARENT = 3'd2;

  // Frame length limits.
  localparam logic [LEN_W-1:0] MAX_BYTES        = LEN_W'(8);
  localparam logic [LEN_W-1:0] MIN_LEN_HEADING  = LEN_W'(7);
  localparam logic [LEN_W-1:0] MIN_LEN_ATTITUDE = LEN_W'(7);
  localparam logic [LEN_W-1:0] MIN_LEN_SPEED    = LEN_W'(3);
  localparam logic [LEN_W-1:0] MIN_LEN_DEPTH    = LEN_W'(7);
  localparam logic [LEN_W-1:0] MIN_LEN_POSITION = LEN_W'(8);
  localparam logic [LEN_W-1:0] MIN_LEN_COG_SOG  = LEN_W'(6);
  localparam logic [LEN_W-1:0] MIN_LEN_WIND     = LEN_W'(6);
  localparam logic [LEN_W-1:0] MIN_LEN_WATER_T  = LEN_W'(3);

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 4'd0,
    KIND_HEADING  = 4'd1,
    KIND_ATTITUDE = 4'd2,
    KIND_SPEED    = 4'd3,
    KIND_DEPTH    = 4'd4,
    KIND_POSITION = 4'd5,
    KIND_COG_SOG  = 4'd6,
    KIND_WIND     = 4'd7,
    KIND_WATER_T  = 4'd8,
    KIND_UNKNOWN  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    SCALE_ANGLE,
    SCALE_KNOTS,
    SCALE_CENTI,
    SCALE_MILLI,
    SCALE_E7
  } scale_t;

  // One quantity to scale: sign and magnitude of the raw count plus the unit factor.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    scale_t           scale;
  } lane_op_t;

  // Everything about a frame that does not pass through the multipliers.
  typedef struct packed {
    logic [GROUP_W-1:0] group_number;
    logic [PRIO_W-1:0]  msg_priority;
    logic [ADDR_W-1:0]  source_address;
    kind_t              kind;
    logic               decoded_ok;
    logic               has_a;
    logic               has_b;
    logic               has_c;
    logic               wind_apparent;
  } hdr_t;

  // Load enables for the two register stages inside a scaling lane.
  typedef struct packed {
    logic ld_prod;
    logic ld_round;
  } lane_ctl_t;

  // Reciprocal coefficient for a unit factor.
  function automatic logic [COEFF_W-1:0] scale_coeff(input scale_t sel);
    logic [COEFF_W-1:0] coeff;
    unique case (sel)
      SCALE_ANGLE: coeff = COEFF_ANGLE;
      SCALE_KNOTS: coeff = COEFF_KNOTS;
      SCALE_CENTI: coeff = COEFF_CENTI;
      SCALE_MILLI: coeff = COEFF_MILLI;
      SCALE_E7:    coeff = COEFF_E7;
      default:     coeff = '0;
    endcase
    return coeff;
  endfunction

endpackage

@@ rtl/n2kfd_decode.sv @@
module n2kfd_decode (
  input  logic                           is_extended,
  input  logic [n2kfd_pkg::ID_W-1:0]      frame_id,
  input  logic [n2kfd_pkg::LEN_W-1:0]     byte_count,
  input  logic [n2kfd_pkg::PAYLOAD_W-1:0] payload,
  output n2kfd_pkg::hdr_t                 hdr,
  output n2kfd_pkg::lane_op_t             op_a,
  output n2kfd_pkg::lane_op_t             op_b,
  output n2kfd_pkg::lane_op_t             op_c
);
  import n2kfd_pkg::*;

  logic [LEN_W-1:0]   len;
  logic [7:0]         pf;
  logic [GROUP_W-1:0] pgn;
  kind_t              kind;
  logic [15:0]        f16_1;
  logic [15:0]        f16_2;
  logic [15:0]        f16_3;
  logic [15:0]        f16_4;
  logic [15:0]        f16_5;
  logic [31:0]        f32_0;
  logic [31:0]        f32_1;
  logic [31:0]        f32_4;
  logic [7:0]         byte5;

  // Signed raw count to sign and magnitude.
  function automatic lane_op_t op_signed(input logic [MAG_W-1:0] raw, input scale_t sel);
    lane_op_t op;
    op.neg   = raw[MAG_W-1];
    op.mag   = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
    op.scale = sel;
    return op;
  endfunction

  function automatic lane_op_t op_unsigned(input logic [MAG_W-1:0] raw, input scale_t sel);
    lane_op_t op;
    op.neg   = 1'b0;
    op.mag   = raw;
    op.scale = sel;
    return op;
  endfunction

  function automatic logic [MAG_W-1:0] sext16(input logic [15:0] x);
    return {{(MAG_W - 16){x[15]}}, x};
  endfunction

  // Byte counts above eight count as eight.
  assign len = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;

  // Group number: DP and PF always, PS only for the PDU2 format.
  assign pf  = frame_id[23:16];
  assign pgn = {1'b0, frame_id[24], pf, (pf >= PF_PDU2_MIN) ? frame_id[15:8] : 8'h00};

  // Little-endian payload fields.
  assign f16_1 = payload[8 +: 16];
  assign f16_2 = payload[16 +: 16];
  assign f16_3 = payload[24 +: 16];
  assign f16_4 = payload[32 +: 16];
  assign f16_5 = payload[40 +: 16];
  assign f32_0 = payload[0 +: 32];
  assign f32_1 = payload[8 +: 32];
  assign f32_4 = payload[32 +: 32];
  assign byte5 = payload[40 +: 8];

  // Match the group number against the known messages.
  always_comb begin
    unique case (pgn)
      PGN_HEADING:  kind = KIND_HEADING;
      PGN_ATTITUDE: kind = KIND_ATTITUDE;
      PGN_SPEED:    kind = KIND_SPEED;
      PGN_DEPTH:    kind = KIND_DEPTH;
      PGN_POSITION: kind = KIND_POSITION;
      PGN_COG_SOG:  kind = KIND_COG_SOG;
      PGN_WIND:     kind = KIND_WIND;
      PGN_WATER_T:  kind = KIND_WATER_T;
      default:      kind = KIND_UNKNOWN;
    endcase
  end

  // Field selection, presence flags and unit factor for each quantity.
  always_comb begin
    hdr  = '0;
    op_a = '0;
    op_b = '0;
    op_c = '0;
    if (is_extended) begin
      hdr.group_number   = pgn;
      hdr.msg_priority   = frame_id[28:26];
      hdr.source_address = frame_id[7:0];
      hdr.kind           = kind;
      unique case (kind)
        KIND_HEADING: begin
          if (len >= MIN_LEN_HEADING) begin
            hdr.has_a      = (f16_1 != NA_S16);
            hdr.has_b      = (f16_5 != NA_S16);
            hdr.decoded_ok = (f16_1 != NA_S16);
            op_a = op_signed(sext16(f16_1), SCALE_ANGLE);
            op_b = op_signed(sext16(f16_5), SCALE_ANGLE);
          end
        end
        KIND_ATTITUDE: begin
          if (len >= MIN_LEN_ATTITUDE) begin
            hdr.has_a      = 1'b1;
            hdr.has_b      = 1'b1;
            hdr.has_c      = 1'b1;
            hdr.decoded_ok = 1'b1;
            op_a = op_signed(sext16(f16_1), SCALE_ANGLE);
            op_b = op_signed(sext16(f16_3), SCALE_ANGLE);
            op_c = op_signed(sext16(f16_5), SCALE_ANGLE);
          end
        end
        KIND_SPEED: begin
          if (len >= MIN_LEN_SPEED) begin
            hdr.has_a      = (f16_1 != NA_U16);
            hdr.decoded_ok = (f16_1 != NA_U16);
            op_a = op_unsigned(MAG_W'(f16_1), SCALE_KNOTS);
          end
        end
        KIND_DEPTH: begin
          if (len >= MIN_LEN_DEPTH) begin
            hdr.has_a      = (f32_1 != NA_U32);
            hdr.has_b      = 1'b1;
            hdr.decoded_ok = (f32_1 != NA_U32);
            op_a = op_unsigned(f32_1, SCALE_CENTI);
            op_b = op_signed(sext16(f16_5), SCALE_MILLI);
          end
        end
        KIND_POSITION: begin
          // Longitude is only trusted when latitude is available.
          if (len >= MIN_LEN_POSITION) begin
            hdr.has_a      = (f32_0 != NA_S32);
            hdr.has_b      = (f32_0 != NA_S32);
            hdr.decoded_ok = (f32_0 != NA_S32);
            op_a = op_signed(f32_0, SCALE_E7);
            op_b = op_signed(f32_4, SCALE_E7);
          end
        end
        KIND_COG_SOG: begin
          if (len >= MIN_LEN_COG_SOG) begin
            hdr.has_a      = (f16_2 != NA_U16);
            hdr.has_b      = (f16_4 != NA_U16);
            hdr.decoded_ok = (f16_2 != NA_U16) || (f16_4 != NA_U16);
            op_a = op_unsigned(MAG_W'(f16_2), SCALE_ANGLE);
            op_b = op_unsigned(MAG_W'(f16_4), SCALE_KNOTS);
          end
        end
        KIND_WIND: begin
          if (len >= MIN_LEN_WIND) begin
            hdr.has_a         = (f16_1 != NA_U16);
            hdr.has_b         = (f16_3 != NA_U16);
            hdr.decoded_ok    = (f16_1 != NA_U16) || (f16_3 != NA_U16);
            hdr.wind_apparent = (byte5[2:0] == WIND_REF_APPARENT);
            op_a = op_unsigned(MAG_W'(f16_1), SCALE_KNOTS);
            op_b = op_unsigned(MAG_W'(f16_3), SCALE_ANGLE);
          end
        end
        KIND_WATER_T: begin
          // Hundredths of a kelvin to degrees Celsius: subtract the offset before scaling.
          if (len >= MIN_LEN_WATER_T) begin
            hdr.has_a      = (f16_1 != NA_U16);
            hdr.decoded_ok = (f16_1 != NA_U16);
            op_a = op_signed(MAG_W'(f16_1) - KELVIN_CENTI, SCALE_CENTI);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/n2kfd_scale_lane.sv @@
module n2kfd_scale_lane (
  input  logic                         clk,
  input  n2kfd_pkg::lane_ctl_t         ctl,
  input  n2kfd_pkg::lane_op_t          op,
  output logic [n2kfd_pkg::VALUE_W-1:0] mag_out,
  output logic                         neg_out
);
  import n2kfd_pkg::*;

  logic [COEFF_PAD_W-1:0] coeff;
  logic [PROD_W-1:0]      prod_next [NCHUNK];
  logic [PROD_W-1:0]      prod [NCHUNK];
  logic                   prod_neg;
  logic [SUM_W-1:0]       sum;

  // Reciprocal for the selected unit, zero padded to whole 32-bit chunks.
  assign coeff = COEFF_PAD_W'(scale_coeff(op.scale));

  // One 32x32 partial product per coefficient chunk.
  always_comb begin
    logic [CHUNK_W-1:0] part;
    for (int i = 0; i < NCHUNK; i++) begin
      part         = coeff[CHUNK_W*i +: CHUNK_W];
      prod_next[i] = PROD_W'(op.mag) * PROD_W'(part);
    end
  end

  // Align and add the partial products together with the rounding half.
  always_comb begin
    sum = ROUND_HALF;
    for (int i = 0; i < NCHUNK; i++) begin
      sum = sum + (SUM_W'(prod[i]) << (CHUNK_W * i));
    end
  end

  // Product stage, then rounded magnitude stage.
  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod     <= prod_next;
      prod_neg <= op.neg;
    end
    if (ctl.ld_round) begin
      mag_out <= sum[RECIP_SHIFT +: VALUE_W];
      neg_out <= prod_neg;
    end
  end

endmodule

@@ rtl/nmea2000_frame_decoder.sv @@
// Pipeline: an accepted word passes through five stages in order, input, decode, partial
// products, rounded sum and signed output, to the result port. Throughput: one word per
// cycle while the result port does not push back; each 32x32 multiplier is used once per word.
// Backpressure on the result port stalls only the stages that hold data.
// Reset: rst is synchronous and clears the valid bit of every stage; data registers keep
// their contents.
`include "nmea2000_frame_decoder_macros.svh"

module nmea2000_frame_decoder (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  frame_valid,
  output logic                                  frame_ready,
  input  logic                                  is_extended,
  input  logic [n2kfd_pkg::ID_W-1:0]             frame_id,
  input  logic [n2kfd_pkg::LEN_W-1:0]            byte_count,
  input  logic [n2kfd_pkg::PAYLOAD_W-1:0]        payload,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [n2kfd_pkg::GROUP_W-1:0]          group_number,
  output logic [n2kfd_pkg::PRIO_W-1:0]           msg_priority,
  output logic [n2kfd_pkg::ADDR_W-1:0]           source_address,
  output logic [n2kfd_pkg::KIND_W-1:0]           message_kind,
  output logic                                  decoded_ok,
  output logic signed [n2kfd_pkg::VALUE_W-1:0]   value_a,
  output logic signed [n2kfd_pkg::VALUE_W-1:0]   value_b,
  output logic signed [n2kfd_pkg::VALUE_W-1:0]   value_c,
  output logic                                  has_a,
  output logic                                  has_b,
  output logic                                  has_c,
  output logic                                  wind_apparent
);
  import n2kfd_pkg::*;

  logic                 s1_ready;
  logic                 s2_ready;
  logic                 s3_ready;
  logic                 s4_ready;
  logic                 out_ready;

  logic                 s1_valid;
  logic                 s1_is_extended;
  logic [ID_W-1:0]      s1_frame_id;
  logic [LEN_W-1:0]     s1_byte_count;
  logic [PAYLOAD_W-1:0] s1_payload;

  hdr_t                 dec_hdr;
  lane_op_t             dec_op_a;
  lane_op_t             dec_op_b;
  lane_op_t             dec_op_c;

  logic                 s2_valid;
  hdr_t                 s2_hdr;
  lane_op_t             s2_op_a;
  lane_op_t             s2_op_b;
  lane_op_t             s2_op_c;

  logic                 s3_valid;
  hdr_t                 s3_hdr;
  logic                 s4_valid;
  hdr_t                 s4_hdr;

  lane_ctl_t            lane_ctl;
  logic [VALUE_W-1:0]   mag_a;
  logic [VALUE_W-1:0]   mag_b;
  logic [VALUE_W-1:0]   mag_c;
  logic                 neg_a;
  logic                 neg_b;
  logic                 neg_c;

  function automatic logic [VALUE_W-1:0] apply_sign(input logic [VALUE_W-1:0] mag,
                                                     input logic neg);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // A stage can take a word when it is empty or its word moves on in the same cycle.
  assign out_ready   = !result_valid || result_ready;
  assign s4_ready    = !s4_valid || out_ready;
  assign s3_ready    = !s3_valid || s4_ready;
  assign s2_ready    = !s2_valid || s3_ready;
  assign s1_ready    = !s1_valid || s2_ready;
  assign frame_ready = s1_ready;

  assign lane_ctl.ld_prod  = s3_ready;
  assign lane_ctl.ld_round = s4_ready;

  // Identifier split, message match and field selection.
  n2kfd_decode u_decode (
    .is_extended (s1_is_extended),
    .frame_id    (s1_frame_id),
    .byte_count  (s1_byte_count),
    .payload     (s1_payload),
    .hdr         (dec_hdr),
    .op_a        (dec_op_a),
    .op_b        (dec_op_b),
    .op_c        (dec_op_c)
  );

  // One scaling lane per output value.
  n2kfd_scale_lane u_lane_a (
    .clk     (clk),
    .ctl     (lane_ctl),
    .op      (s2_op_a),
    .mag_out (mag_a),
    .neg_out (neg_a)
  );

  n2kfd_scale_lane u_lane_b (
    .clk     (clk),
    .ctl     (lane_ctl),
    .op      (s2_op_b),
    .mag_out (mag_b),
    .neg_out (neg_b)
  );

  n2kfd_scale_lane u_lane_c (
    .clk     (clk),
    .ctl     (lane_ctl),
    .op      (s2_op_c),
    .mag_out (mag_c),
    .neg_out (neg_c)
  );

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= frame_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (out_ready) result_valid <= s4_valid;
    end
  end

  // Stage data; absent quantities are forced to zero at the output.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_is_extended <= is_extended;
      s1_frame_id    <= frame_id;
      s1_byte_count  <= byte_count;
      s1_payload     <= payload;
    end
    if (s2_ready) begin
      s2_hdr  <= dec_hdr;
      s2_op_a <= dec_op_a;
      s2_op_b <= dec_op_b;
      s2_op_c <= dec_op_c;
    end
    if (s3_ready) s3_hdr <= s2_hdr;
    if (s4_ready) s4_hdr <= s3_hdr;
    if (out_ready) begin
      group_number   <= s4_hdr.group_number;
      msg_priority   <= s4_hdr.msg_priority;
      source_address <= s4_hdr.source_address;
      message_kind   <= s4_hdr.kind;
      decoded_ok     <= s4_hdr.decoded_ok;
      has_a          <= s4_hdr.has_a;
      has_b          <= s4_hdr.has_b;
      has_c          <= s4_hdr.has_c;
      wind_apparent  <= s4_hdr.wind_apparent;
      value_a        <= s4_hdr.has_a ? apply_sign(mag_a, neg_a) : '0;
      value_b        <= s4_hdr.has_b ? apply_sign(mag_b, neg_b) : '0;
      value_c        <= s4_hdr.has_c ? apply_sign(mag_c, neg_c) : '0;
    end
  end

  // Input stalls only when every stage is full and the result port pushes back.
  `N2KFD_ASSERT_IMPLY(a_stall_source, clk, rst, !frame_ready, result_valid && !result_ready, "input stalled without output backpressure")
  // A word held behind a blocked output stays in its stage.
  `N2KFD_ASSERT_NEXT(a_stage_hold, clk, rst, s4_valid && !out_ready, s4_valid, "stage four lost a word while stalled")
  // The third value belongs to attitude alone.
  `N2KFD_ASSERT_IMPLY(a_roll_kind, clk, rst, result_valid && has_c, message_kind == KIND_ATTITUDE, "roll present outside attitude")
  // The wind reference flag belongs to wind alone.
  `N2KFD_ASSERT_IMPLY(a_wind_kind, clk, rst, result_valid && wind_apparent, message_kind == KIND_WIND, "apparent wind flag outside wind")
  // Only a known message can decode.
  `N2KFD_ASSERT_IMPLY(a_ok_kind, clk, rst, result_valid && decoded_ok, (message_kind != KIND_NONE) && (message_kind != KIND_UNKNOWN), "decode flag on unknown message")

endmodule
